// ===== rtl/core/lgls_pkg.sv =====
package lgls_pkg;

  localparam int unsigned LEN_W   = 14;
  localparam int unsigned DEPTH_W = 17;
  localparam int unsigned LINE_W  = 20;
  localparam int unsigned PAIR_W  = 16;
  localparam int unsigned RLIM_W  = 9;
  localparam int unsigned ALIM_W  = 13;

  localparam logic [RLIM_W-1:0] REGEX_LIMIT_RST  = RLIM_W'(256);
  localparam logic [ALIM_W-1:0] ACTION_LIMIT_RST = ALIM_W'(4096);

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  localparam logic CFG_REGEX_LIMIT  = 1'b0;
  localparam logic CFG_ACTION_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ROLE_SEP    = 2'd0,
    ROLE_REGEX  = 2'd1,
    ROLE_ACTION = 2'd2,
    ROLE_EOF    = 2'd3
  } role_t;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_REGEX_OVERFLOW = 4'd1,
    ST_REGEX_NOT_BOL  = 4'd2,
    ST_MISSING_ACTION = 4'd3,
    ST_BAD_GAP        = 4'd4,
    ST_ACTION_OVF     = 4'd5,
    ST_MISSING_BRACE  = 4'd6,
    ST_BAD_TRAIL      = 4'd7,
    ST_NO_PAIRS       = 4'd8
  } status_t;

  typedef enum logic [5:0] {
    PH_REGEX  = 6'b000001,
    PH_BLANK  = 6'b000010,
    PH_GAP    = 6'b000100,
    PH_ACTION = 6'b001000,
    PH_TRAIL  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_count;
    logic [LINE_W-1:0] line_number;
    status_t           status;
    logic              pair_end;
    logic              regex_end;
    logic [7:0]        echo_byte;
  } result_t;

endpackage

// ===== rtl/core/lex_grammar_line_scanner.sv =====
// Tags each byte of a lexer grammar text with its role (separator, regex, action or end of
// file) and reports the running line number, pair count and a sticky status code. One input
// word is taken every cycle and its result word appears in the output register in the next
// cycle; the only stall is back-pressure on the output side. After end of file or an
// error the scanner is finished: further words are echoed with role 0 (3 for end of file)
// and status and counters hold until reset. The user must write the two length limits
// through the cfg port only while no word is in flight; the scanner does not enforce this.
module lex_grammar_line_scanner
  import lgls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // echo_byte, regex_end, pair_end, status, line_number, pair_count
  output logic [1:0]  m_tuser,   // byte_role
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam logic [LEN_W-1:0]   LEN_CAP   = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_CAP = '1;
  localparam logic [LINE_W-1:0]  LINE_CAP  = '1;
  localparam logic [PAIR_W-1:0]  PAIR_CAP  = '1;

  logic [RLIM_W-1:0]  regex_limit;
  logic [ALIM_W-1:0]  action_limit;
  phase_t             phase, phase_next;
  logic               escape_flag, escape_flag_next;
  logic               class_flag, class_flag_next;
  logic               quote_flag, quote_flag_next;
  logic [DEPTH_W-1:0] brace_depth, brace_depth_next;
  logic [LEN_W-1:0]   length_count, length_count_next;
  logic [LINE_W-1:0]  line_count, line_count_next;
  logic [PAIR_W-1:0]  pairs_seen, pairs_seen_next;
  status_t            error_code, error_code_next;

  result_t            result, result_next;
  role_t              role, role_next;

  logic               accept;
  logic [7:0]         c;
  logic               eof;
  logic               blank;
  logic [LEN_W-1:0]   len_inc;
  logic [LINE_W-1:0]  line_inc;
  logic [DEPTH_W-1:0] depth_dec;
  logic               rend, pend;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign eof      = s_tuser;
  assign blank    = (c == CH_SPACE) || (c == CH_TAB);
  assign len_inc  = (length_count == LEN_CAP) ? LEN_CAP : length_count + LEN_W'(1);
  assign line_inc = (line_count == LINE_CAP) ? LINE_CAP : line_count + LINE_W'(1);
  assign depth_dec = (brace_depth == '0) ? '0 : brace_depth - DEPTH_W'(1);

  always_comb begin
    phase_next        = phase;
    escape_flag_next  = escape_flag;
    class_flag_next   = class_flag;
    quote_flag_next   = quote_flag;
    brace_depth_next  = brace_depth;
    length_count_next = length_count;
    line_count_next   = line_count;
    pairs_seen_next   = pairs_seen;
    error_code_next   = error_code;
    role_next         = ROLE_SEP;
    rend              = 1'b0;
    pend              = 1'b0;

    if (phase == PH_DONE) begin
      role_next = eof ? ROLE_EOF : ROLE_SEP;
    end else if (eof) begin
      role_next = ROLE_EOF;
      if (phase == PH_REGEX && length_count != '0) begin
        error_code_next = ST_MISSING_ACTION;
      end else if (phase == PH_GAP) begin
        error_code_next = ST_MISSING_ACTION;
      end else if (phase == PH_ACTION) begin
        error_code_next = ST_MISSING_BRACE;
      end else if (phase == PH_BLANK) begin
        line_count_next = line_inc;
      end
      if (error_code == ST_OK && phase != PH_GAP && phase != PH_ACTION
          && !(phase == PH_REGEX && length_count != '0) && pairs_seen == '0) begin
        error_code_next = ST_NO_PAIRS;
      end
      phase_next = PH_DONE;
    end else begin
      case (phase)
        PH_REGEX: begin
          length_count_next = len_inc;
          role_next = ROLE_REGEX;
          if (len_inc == LEN_W'(regex_limit)) begin
            role_next       = ROLE_SEP;
            error_code_next = ST_REGEX_OVERFLOW;
            phase_next      = PH_DONE;
          end else if (escape_flag) begin
            escape_flag_next = 1'b0;
          end else if (c == CH_BACKSLASH) begin
            escape_flag_next = 1'b1;
          end else if (c == CH_LBRACKET) begin
            class_flag_next = 1'b1;
          end else if (c == CH_RBRACKET && class_flag) begin
            class_flag_next = 1'b0;
          end else if (blank && !class_flag) begin
            role_next = ROLE_SEP;
            if (len_inc == LEN_W'(1)) begin
              phase_next = PH_BLANK;
            end else begin
              rend       = 1'b1;
              phase_next = PH_GAP;
            end
            length_count_next = '0;
            escape_flag_next  = 1'b0;
            class_flag_next   = 1'b0;
          end else if (c == CH_NEWLINE) begin
            role_next = ROLE_SEP;
            if (len_inc == LEN_W'(1)) begin
              line_count_next   = line_inc;
              length_count_next = '0;
              escape_flag_next  = 1'b0;
              class_flag_next   = 1'b0;
              quote_flag_next   = 1'b0;
              brace_depth_next  = '0;
            end else begin
              error_code_next = ST_MISSING_ACTION;
              phase_next      = PH_DONE;
            end
          end
        end
        PH_BLANK: begin
          if (c == CH_NEWLINE) begin
            line_count_next   = line_inc;
            phase_next        = PH_REGEX;
            length_count_next = '0;
            escape_flag_next  = 1'b0;
            class_flag_next   = 1'b0;
            quote_flag_next   = 1'b0;
            brace_depth_next  = '0;
          end else if (!blank) begin
            error_code_next = ST_REGEX_NOT_BOL;
            phase_next      = PH_DONE;
          end
        end
        PH_GAP: begin
          if (c == CH_LBRACE) begin
            role_next         = ROLE_ACTION;
            length_count_next = LEN_W'(1);
            brace_depth_next  = DEPTH_W'(1);
            quote_flag_next   = 1'b0;
            escape_flag_next  = 1'b0;
            phase_next        = PH_ACTION;
          end else if (!blank) begin
            error_code_next = ST_BAD_GAP;
            phase_next      = PH_DONE;
          end
        end
        PH_ACTION: begin
          length_count_next = len_inc;
          role_next = ROLE_ACTION;
          if (len_inc == LEN_W'(action_limit)) begin
            role_next       = ROLE_SEP;
            error_code_next = ST_ACTION_OVF;
            phase_next      = PH_DONE;
          end else begin
            if (c == CH_NEWLINE) begin
              line_count_next = line_inc;
            end
            if (quote_flag) begin
              if (escape_flag) begin
                escape_flag_next = 1'b0;
              end else if (c == CH_BACKSLASH) begin
                escape_flag_next = 1'b1;
              end else if (c == CH_QUOTE) begin
                quote_flag_next = 1'b0;
              end
            end else if (c == CH_QUOTE) begin
              quote_flag_next = 1'b1;
            end else if (c == CH_LBRACE) begin
              brace_depth_next = (brace_depth == DEPTH_CAP) ? DEPTH_CAP
                                                            : brace_depth + DEPTH_W'(1);
            end else if (c == CH_RBRACE) begin
              brace_depth_next = depth_dec;
              if (depth_dec == '0) begin
                pend              = 1'b1;
                pairs_seen_next   = (pairs_seen == PAIR_CAP) ? PAIR_CAP
                                                             : pairs_seen + PAIR_W'(1);
                length_count_next = '0;
                phase_next        = PH_TRAIL;
              end
            end
          end
        end
        PH_TRAIL: begin
          if (c == CH_NEWLINE) begin
            line_count_next   = line_inc;
            phase_next        = PH_REGEX;
            length_count_next = '0;
            escape_flag_next  = 1'b0;
            class_flag_next   = 1'b0;
            quote_flag_next   = 1'b0;
            brace_depth_next  = '0;
          end else if (!blank) begin
            error_code_next = ST_BAD_TRAIL;
            phase_next      = PH_DONE;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    result_next.echo_byte   = eof ? 8'd0 : c;
    result_next.regex_end   = rend;
    result_next.pair_end    = pend;
    result_next.status      = error_code_next;
    result_next.line_number = line_count_next;
    result_next.pair_count  = pairs_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regex_limit  <= REGEX_LIMIT_RST;
      action_limit <= ACTION_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGEX_LIMIT:  regex_limit  <= cfg_data[RLIM_W-1:0];
        CFG_ACTION_LIMIT: action_limit <= cfg_data[ALIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_REGEX;
      escape_flag  <= 1'b0;
      class_flag   <= 1'b0;
      quote_flag   <= 1'b0;
      brace_depth  <= '0;
      length_count <= '0;
      line_count   <= LINE_W'(1);
      pairs_seen   <= '0;
      error_code   <= ST_OK;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        escape_flag  <= escape_flag_next;
        class_flag   <= class_flag_next;
        quote_flag   <= quote_flag_next;
        brace_depth  <= brace_depth_next;
        length_count <= length_count_next;
        line_count   <= line_count_next;
        pairs_seen   <= pairs_seen_next;
        error_code   <= error_code_next;
      end
      if (s_tready) begin
        m_tvalid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
      role   <= role_next;
    end
  end

  assign m_tdata = {6'd0, result};
  assign m_tuser = role;

endmodule

// ===== bench/line_scan_checker.sv =====
`timescale 1ns / 1ps

module line_scan_checker
  import lgls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // end_of_file
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // echo_byte, regex_end, pair_end, status, line_number, pair_count
  input  logic [1:0]  m_tuser,   // byte_role
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned COUNT_MAX = 32'h1FFFF;
  localparam int unsigned LINE_MAX  = 32'hFFFFF;
  localparam int unsigned PAIR_MAX  = 32'hFFFF;

  typedef struct packed {
    logic [5:0] pad;
    result_t    res;
    role_t      role;
  } scan_word_t;

  scan_word_t        expected_words[$];
  phase_t            scan_phase;
  logic              in_escape;
  logic              in_class;
  logic              in_quote;
  int unsigned       depth;
  int unsigned       run_len;
  int unsigned       line_no;
  int unsigned       pairs;
  status_t           err;
  logic [RLIM_W-1:0] rlim;
  logic [ALIM_W-1:0] alim;

  function automatic int unsigned bump(input int unsigned v, input int unsigned cap);
    return (v < cap) ? v + 1 : cap;
  endfunction

  function automatic void begin_line();
    scan_phase = PH_REGEX;
    run_len = 0;
    in_escape = 1'b0;
    in_class = 1'b0;
    in_quote = 1'b0;
    depth = 0;
  endfunction

  function automatic void halt(input status_t code);
    err = code;
    scan_phase = PH_DONE;
  endfunction

  function automatic scan_word_t predict_word(input logic [7:0] ch, input logic eof);
    scan_word_t w;
    logic blank;
    w = '0;
    w.role = ROLE_SEP;
    blank = (ch == CH_SPACE) || (ch == CH_TAB);
    if (scan_phase == PH_DONE) begin
      if (eof) w.role = ROLE_EOF;
    end else if (eof) begin
      w.role = ROLE_EOF;
      if (scan_phase == PH_REGEX && run_len != 0) err = ST_MISSING_ACTION;
      else if (scan_phase == PH_GAP) err = ST_MISSING_ACTION;
      else if (scan_phase == PH_ACTION) err = ST_MISSING_BRACE;
      else if (scan_phase == PH_BLANK) line_no = bump(line_no, LINE_MAX);
      if (err == ST_OK && pairs == 0) err = ST_NO_PAIRS;
      scan_phase = PH_DONE;
    end else begin
      case (scan_phase)
        PH_REGEX: begin
          run_len = bump(run_len, COUNT_MAX);
          w.role = ROLE_REGEX;
          if (run_len == rlim) begin
            w.role = ROLE_SEP;
            halt(ST_REGEX_OVERFLOW);
          end else if (in_escape) begin
            in_escape = 1'b0;
          end else if (ch == CH_BACKSLASH) begin
            in_escape = 1'b1;
          end else if (ch == CH_LBRACKET) begin
            in_class = 1'b1;
          end else if (ch == CH_RBRACKET && in_class) begin
            in_class = 1'b0;
          end else if (blank && !in_class) begin
            w.role = ROLE_SEP;
            if (run_len == 1) begin
              scan_phase = PH_BLANK;
            end else begin
              w.res.regex_end = 1'b1;
              scan_phase = PH_GAP;
            end
            run_len = 0;
            in_escape = 1'b0;
            in_class = 1'b0;
          end else if (ch == CH_NEWLINE) begin
            w.role = ROLE_SEP;
            if (run_len == 1) begin
              line_no = bump(line_no, LINE_MAX);
              begin_line();
            end else begin
              halt(ST_MISSING_ACTION);
            end
          end
        end
        PH_BLANK: begin
          if (ch == CH_NEWLINE) begin
            line_no = bump(line_no, LINE_MAX);
            begin_line();
          end else if (!blank) begin
            halt(ST_REGEX_NOT_BOL);
          end
        end
        PH_GAP: begin
          if (ch == CH_LBRACE) begin
            w.role = ROLE_ACTION;
            run_len = 1;
            depth = 1;
            in_quote = 1'b0;
            in_escape = 1'b0;
            scan_phase = PH_ACTION;
          end else if (!blank) begin
            halt(ST_BAD_GAP);
          end
        end
        PH_ACTION: begin
          run_len = bump(run_len, COUNT_MAX);
          w.role = ROLE_ACTION;
          if (run_len == alim) begin
            w.role = ROLE_SEP;
            halt(ST_ACTION_OVF);
          end else begin
            if (ch == CH_NEWLINE) line_no = bump(line_no, LINE_MAX);
            if (in_quote) begin
              if (in_escape) in_escape = 1'b0;
              else if (ch == CH_BACKSLASH) in_escape = 1'b1;
              else if (ch == CH_QUOTE) in_quote = 1'b0;
            end else if (ch == CH_QUOTE) begin
              in_quote = 1'b1;
            end else if (ch == CH_LBRACE) begin
              depth = bump(depth, COUNT_MAX);
            end else if (ch == CH_RBRACE) begin
              depth = (depth != 0) ? depth - 1 : 0;
              if (depth == 0) begin
                w.res.pair_end = 1'b1;
                pairs = bump(pairs, PAIR_MAX);
                run_len = 0;
                scan_phase = PH_TRAIL;
              end
            end
          end
        end
        default: begin
          if (ch == CH_NEWLINE) begin
            line_no = bump(line_no, LINE_MAX);
            begin_line();
          end else if (!blank) begin
            halt(ST_BAD_TRAIL);
          end
        end
      endcase
    end
    w.res.echo_byte = eof ? 8'h00 : ch;
    w.res.status = err;
    w.res.line_number = line_no[LINE_W-1:0];
    w.res.pair_count = pairs[PAIR_W-1:0];
    return w;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    scan_word_t want;
    scan_word_t got;
    if (rst) begin
      begin_line();
      line_no = 1;
      pairs = 0;
      err = ST_OK;
      rlim = REGEX_LIMIT_RST;
      alim = ACTION_LIMIT_RST;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REGEX_LIMIT) rlim = cfg_data[RLIM_W-1:0];
        else alim = cfg_data[ALIM_W-1:0];
      end
      if (s_tvalid && s_tready) expected_words.push_back(predict_word(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        got.pad = m_tdata[55:50];
        got.res = m_tdata[49:0];
        got.role = role_t'(m_tuser);
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t unexpected word: expected none actual %0h", $time, m_tdata);
        end else begin
          want = expected_words.pop_front();
          report("echo_byte", 32'(want.res.echo_byte), 32'(got.res.echo_byte));
          report("byte_role", 32'(want.role), 32'(got.role));
          report("regex_end", 32'(want.res.regex_end), 32'(got.res.regex_end));
          report("pair_end", 32'(want.res.pair_end), 32'(got.res.pair_end));
          report("status", 32'(want.res.status), 32'(got.res.status));
          report("line_number", 32'(want.res.line_number), 32'(got.res.line_number));
          report("pair_count", 32'(want.res.pair_count), 32'(got.res.pair_count));
          report("padding", 32'(want.pad), 32'(got.pad));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/tb_lex_grammar_line_scanner.sv =====
`timescale 1ns / 1ps

module tb_lex_grammar_line_scanner;
  import lgls_pkg::*;

  typedef enum int {
    BK_REGEX,
    BK_CLASS,
    BK_ACTION,
    BK_QUOTE,
    BK_GAP_BAD
  } byte_kind_t;

  localparam logic [7:0] OPENING [24] = '{
    8'hFF, CH_LBRACKET, CH_SPACE, 8'h00, CH_RBRACKET, CH_BACKSLASH, CH_SPACE, CH_SPACE,
    CH_TAB, CH_LBRACE, 8'h61, CH_LBRACE, CH_QUOTE, CH_RBRACE, CH_BACKSLASH, CH_QUOTE,
    CH_QUOTE, CH_RBRACE, 8'h80, CH_RBRACE, CH_TAB, CH_NEWLINE, CH_NEWLINE, CH_TAB
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // data_byte
  logic        s_tuser = 1'b0;    // end_of_file
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;           // echo_byte, regex_end, pair_end, status, line_number, pair_count
  logic [1:0]  m_tuser;           // byte_role
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_REGEX_LIMIT;
  logic [12:0] cfg_data = 13'd0;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;
  int unsigned word_count = 0;
  int unsigned regex_cap = 256;
  int unsigned action_cap = 4096;
  int unsigned ending;
  logic [7:0]  line_buf[$];

  lex_grammar_line_scanner uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  line_scan_checker scan_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 9);
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] pick_byte(input byte_kind_t k);
    logic [7:0] b;
    logic bad;
    do begin
      b = 8'($urandom_range(255));
      case (k)
        BK_REGEX: bad = b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE ||
                        b == CH_BACKSLASH || b == CH_LBRACKET;
        BK_CLASS: bad = b == CH_RBRACKET || b == CH_BACKSLASH || b == CH_NEWLINE;
        BK_ACTION: bad = b == CH_QUOTE || b == CH_LBRACE || b == CH_RBRACE;
        BK_QUOTE: bad = b == CH_QUOTE || b == CH_BACKSLASH;
        default: bad = b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE || b == CH_LBRACE;
      endcase
    end while (bad);
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eof);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    word_count++;
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) send_word(line_buf[i], 1'b0);
    line_buf.delete();
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input int unsigned rl, input int unsigned al);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REGEX_LIMIT;
    cfg_data <= 13'(rl);
    @(posedge clk);
    cfg_index <= CFG_ACTION_LIMIT;
    cfg_data <= 13'(al);
    @(posedge clk);
    cfg_we <= 1'b0;
    regex_cap = rl;
    action_cap = al;
  endtask

  task automatic add_blanks(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(hi, lo)) line_buf.push_back(pick_blank());
  endtask

  // regex of complete tokens, never longer than maxlen bytes
  task automatic add_regex(input int unsigned maxlen);
    int unsigned target;
    int unsigned used;
    int unsigned room;
    int unsigned n;
    target = ($urandom_range(15) == 0) ? maxlen : $urandom_range(lesser(maxlen, 10), 1);
    used = 0;
    while (used < target) begin
      room = target - used;
      n = $urandom_range(5);
      if (n == 0 && room >= 2) begin
        line_buf.push_back(CH_BACKSLASH);
        line_buf.push_back(8'($urandom_range(255)));
        used += 2;
      end else if (n == 1 && room >= 3) begin
        line_buf.push_back(CH_LBRACKET);
        n = $urandom_range(lesser(room - 2, 6), 1);
        repeat (n) line_buf.push_back($urandom_range(2) ? pick_byte(BK_CLASS) : pick_blank());
        line_buf.push_back(CH_RBRACKET);
        used += n + 2;
      end else begin
        line_buf.push_back(pick_byte(BK_REGEX));
        used++;
      end
    end
  endtask

  // brace-balanced action of maxlen bytes at most, braces included
  task automatic add_action(input int unsigned maxlen);
    int unsigned target;
    int unsigned used;
    int unsigned open;
    int unsigned room;
    int unsigned n;
    int unsigned k;
    target = ($urandom_range(15) == 0) ? lesser(maxlen, 300)
                                       : $urandom_range(lesser(maxlen, 14), 2);
    line_buf.push_back(CH_LBRACE);
    used = 1;
    open = 1;
    while (used + open < target) begin
      room = target - used - open;
      n = $urandom_range(5);
      if (n == 0 && room >= 2) begin
        line_buf.push_back(CH_LBRACE);
        open++;
        used++;
      end else if (n == 1 && open > 1) begin
        line_buf.push_back(CH_RBRACE);
        open--;
        used++;
      end else if (n == 2 && room >= 2) begin
        line_buf.push_back(CH_QUOTE);
        n = $urandom_range(lesser(room - 2, 6));
        k = 0;
        while (k < n) begin
          if ($urandom_range(3) == 0 && n - k >= 2) begin
            line_buf.push_back(CH_BACKSLASH);
            line_buf.push_back(8'($urandom_range(255)));
            k += 2;
          end else begin
            line_buf.push_back(pick_byte(BK_QUOTE));
            k++;
          end
        end
        line_buf.push_back(CH_QUOTE);
        used += n + 2;
      end else begin
        line_buf.push_back(($urandom_range(7) == 0) ? CH_NEWLINE : pick_byte(BK_ACTION));
        used++;
      end
    end
    repeat (open) line_buf.push_back(CH_RBRACE);
  endtask

  task automatic add_head();
    add_regex(regex_cap - 2);
    line_buf.push_back(pick_blank());
    add_blanks(0, 2);
  endtask

  task automatic add_pair();
    add_head();
    add_action(action_cap - 1);
    add_blanks(0, 2);
  endtask

  task automatic scan_lines(input int unsigned goal, input logic with_pairs);
    while (word_count < goal) begin
      if (with_pairs && $urandom_range(9) != 0) begin
        add_pair();
      end else begin
        add_blanks(0, 3);
      end
      line_buf.push_back(CH_NEWLINE);
      send_buf();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(256, 4096);
    foreach (OPENING[i]) line_buf.push_back(OPENING[i]);
    line_buf.push_back(CH_NEWLINE);
    send_buf();
    scan_lines(500, 1'b1);

    settle();
    configure($urandom_range(30, 3), $urandom_range(60, 3));
    calm = 1'b1;
    scan_lines(1150, 1'b1);
    calm = 1'b0;

    settle();
    configure(2, 2);
    scan_lines(1210, 1'b0);

    settle();
    configure($urandom_range(40, 3), $urandom_range(80, 3));
    scan_lines(1700, 1'b1);

    // one way of ending the text; the scanner stays finished afterwards
    ending = $urandom_range(11);
    case (ending)
      0: ;
      1: add_blanks(1, 3);
      2: add_regex(regex_cap - 2);
      3: add_head();
      4: begin
        add_head();
        line_buf.push_back(CH_LBRACE);
        repeat ($urandom_range(lesser(action_cap - 2, 10))) line_buf.push_back(pick_byte(BK_ACTION));
      end
      5: add_pair();
      6: repeat (regex_cap) line_buf.push_back(pick_byte(BK_REGEX));
      7: begin
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(pick_byte(BK_REGEX));
      end
      8: begin
        add_regex(regex_cap - 2);
        line_buf.push_back(CH_NEWLINE);
      end
      9: begin
        add_head();
        line_buf.push_back(pick_byte(BK_GAP_BAD));
      end
      10: begin
        add_head();
        line_buf.push_back(CH_LBRACE);
        repeat (action_cap - 1) line_buf.push_back(pick_byte(BK_ACTION));
      end
      default: begin
        add_pair();
        line_buf.push_back(pick_byte(BK_REGEX));
      end
    endcase
    send_buf();
    if (ending <= 5) send_word(8'($urandom_range(255)), 1'b1);
    repeat ($urandom_range(40, 20)) send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
    send_word(8'($urandom_range(255)), 1'b1);

    s_tvalid <= 1'b0;
    for (int i = 0; i < 1000 && pending != 0; i++) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("scanned %0d words under four limit settings, ending case %0d", word_count,
             ending);
    $display("directed line, pair and blank lines, then finished-state echo");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
